@@ rtl/rejection_sampled_shuffle_assert.svh @@
// Assertion macros shared by the shuffle RTL.
// Plain header; no dependencies beyond the including module's clock and reset.
`ifndef REJECTION_SAMPLED_SHUFFLE_ASSERT_SVH
`define REJECTION_SAMPLED_SHUFFLE_ASSERT_SVH

// Same-cycle implication.
`define RSS_AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSS_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rss_pkg.sv @@
// Shared constants and controller/datapath interface types for the shuffle.
// No dependencies.
package rss_pkg;

    localparam int WORD_W        = 32;
    localparam int DIGIT_W       = 4;
    localparam int SIZE_W        = 5;
    localparam int ITEM_NUM_W    = 4;
    localparam int MAX_ITEMS_DEF = 16;
    localparam int SIZE_RST      = 15;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [PADDR_W-1:0] ADDR_PERM_SIZE = 3'd0;

    // memory read address source
    typedef enum logic [1:0] {
        RSEL_POS,
        RSEL_J,
        RSEL_K
    } t_rsel;

    // memory write target
    typedef enum logic {
        WSEL_POS,
        WSEL_J
    } t_wsel;

    typedef struct packed {
        logic  start_mod;
        logic  rd_en;
        t_rsel rsel;
        logic  capture_pos;
        logic  wr_en;
        t_wsel wsel;
        logic  dec_pos;
        logic  emit_clr;
        logic  emit_inc;
        logic  load_out;
        logic  restart;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic reject;
        logic pos_is_one;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

@@ rtl/rss_mod.sv @@
// Radix-16 restoring remainder unit: word mod n, four bits per cycle.
// Depends on rss_pkg.
module rss_mod
    import rss_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [WORD_W-1:0]                    i_word,
    input  logic [$clog2(MAX_ITEMS + 1)-1:0]     i_bound,
    output logic [$clog2(MAX_ITEMS + 1)-1:0]     o_rem,
    output logic                                 o_done
);

    localparam int NW    = $clog2(MAX_ITEMS + 1);
    localparam int STEPS = WORD_W / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [WORD_W-1:0] r_word, n_word;
    logic [NW-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    always_comb begin
        logic [NW:0] t;
        n_rem  = r_rem;
        n_word = r_word;
        for (int b = 0; b < DIGIT_W; b++) begin
            t = {n_rem, n_word[WORD_W-1]};
            if (t >= {1'b0, i_bound}) begin
                t = t - {1'b0, i_bound};
            end
            n_rem  = t[NW-1:0];
            n_word = {n_word[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= n_word;
            r_rem  <= n_rem;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

@@ rtl/rss_datapath.sv @@
// Shuffle datapath: item memory with valid bits, position, reject test,
// emit counter and output register. Depends on rss_pkg and rss_mod.
module rss_datapath
    import rss_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_restart,
    input  logic [SIZE_W-1:0]     i_size,
    input  logic [WORD_W-1:0]     i_random_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ITEM_NUM_W-1:0] o_item_number,
    output logic                  o_is_last
);

    localparam int PW = $clog2(MAX_ITEMS);
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int IW = (PW > ITEM_NUM_W) ? PW : ITEM_NUM_W;
    localparam int CW = (PW + 1 > SIZE_W) ? PW + 1 : SIZE_W;
    // reset position follows the reset size clipped to the store depth
    localparam int POS_INIT = ((SIZE_RST > MAX_ITEMS) ? MAX_ITEMS : SIZE_RST) - 1;

    logic [IW-1:0]        mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_vld;
    logic [IW-1:0]        r_rd_data;
    logic                 r_rd_vld;
    logic [PW-1:0]        r_rd_addr;
    logic [IW-1:0]        w_rd_val;

    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        r_k;
    logic [IW-1:0]        r_vpos;
    logic [WORD_W-1:0]    r_word;

    logic [NW-1:0]        w_bound;
    logic [NW-1:0]        w_rem;
    logic [PW-1:0]        w_j;
    logic [WORD_W:0]      w_chk;
    logic                 w_mod_done;

    logic [PW-1:0]        w_raddr;
    logic [PW-1:0]        w_waddr;
    logic [IW-1:0]        w_wdata;

    logic                 r_o_valid;
    logic [ITEM_NUM_W-1:0] r_o_item;
    logic                 r_o_last;
    logic                 w_out_free;
    logic                 w_emit_last;

    assign w_bound = NW'(r_pos) + NW'(1);
    assign w_j     = w_rem[PW-1:0];

    rss_mod #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_mod),
        .i_word  (i_random_word),
        .i_bound (w_bound),
        .o_rem   (w_rem),
        .o_done  (w_mod_done)
    );

    // word lies at or past the limit iff word - rem + n - 1 overflows 32 bits
    assign w_chk = {1'b0, r_word} + (WORD_W + 1)'(w_bound) - (WORD_W + 1)'(w_rem)
                   - (WORD_W + 1)'(1);

    always_comb begin
        case (i_cmd.rsel)
            RSEL_POS: w_raddr = r_pos;
            RSEL_J:   w_raddr = w_j;
            RSEL_K:   w_raddr = r_k;
            default:  w_raddr = r_pos;
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            WSEL_POS: begin
                w_waddr = r_pos;
                w_wdata = w_rd_val;
            end
            WSEL_J: begin
                w_waddr = w_j;
                w_wdata = r_vpos;
            end
            default: begin
                w_waddr = r_pos;
                w_wdata = w_rd_val;
            end
        endcase
    end

    // unwritten entries read as their own index
    assign w_rd_val = r_rd_vld ? r_rd_data : IW'(r_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[w_raddr];
            r_rd_vld  <= r_vld[w_raddr];
            r_rd_addr <= w_raddr;
        end
        if (i_cmd.capture_pos) begin
            r_vpos <= w_rd_val;
        end
        if (i_cmd.start_mod) begin
            r_word <= i_random_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pos <= PW'(POS_INIT);
            r_k   <= '0;
        end else begin
            if (i_restart) begin
                r_vld <= '0;
                r_pos <= PW'(i_size - SIZE_W'(1));
            end else begin
                if (i_cmd.wr_en) begin
                    r_vld[w_waddr] <= 1'b1;
                end
                if (i_cmd.dec_pos) begin
                    r_pos <= r_pos - PW'(1);
                end
            end
            if (i_cmd.emit_clr) begin
                r_k <= '0;
            end else if (i_cmd.emit_inc) begin
                r_k <= r_k + PW'(1);
            end
        end
    end

    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_emit_last = (CW'(r_k) + CW'(1)) == CW'(i_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_item <= w_rd_val[ITEM_NUM_W-1:0];
            r_o_last <= w_emit_last;
        end
    end

    assign o_sts.mod_done   = w_mod_done;
    assign o_sts.reject     = w_chk[WORD_W];
    assign o_sts.pos_is_one = (r_pos == PW'(1));
    assign o_sts.out_free   = w_out_free;
    assign o_sts.emit_last  = w_emit_last;

    assign o_valid       = r_o_valid;
    assign o_item_number = r_o_item;
    assign o_is_last     = r_o_last;

endmodule

@@ rtl/rss_ctrl.sv @@
// Shuffle sequencer: steps each request through remainder, reject test,
// swap and emit. Depends on rss_pkg and rejection_sampled_shuffle_assert.svh.
`include "rejection_sampled_shuffle_assert.svh"

module rss_ctrl
    import rss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_RD_J,
        S_WR_POS,
        S_WR_J,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state           = r_state;
        o_cmd.start_mod   = 1'b0;
        o_cmd.rd_en       = 1'b0;
        o_cmd.rsel        = RSEL_POS;
        o_cmd.capture_pos = 1'b0;
        o_cmd.wr_en       = 1'b0;
        o_cmd.wsel        = WSEL_POS;
        o_cmd.dec_pos     = 1'b0;
        o_cmd.emit_clr    = 1'b0;
        o_cmd.emit_inc    = 1'b0;
        o_cmd.load_out    = 1'b0;
        o_cmd.restart     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start_mod = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.mod_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // fetch entry at position; harmless if the word is dropped
                o_cmd.rd_en = 1'b1;
                o_cmd.rsel  = RSEL_POS;
                n_state     = i_sts.reject ? S_IDLE : S_RD_J;
            end
            S_RD_J: begin
                o_cmd.rd_en       = 1'b1;
                o_cmd.rsel        = RSEL_J;
                o_cmd.capture_pos = 1'b1;
                n_state           = S_WR_POS;
            end
            S_WR_POS: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wsel  = WSEL_POS;
                n_state     = S_WR_J;
            end
            S_WR_J: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wsel    = WSEL_J;
                o_cmd.dec_pos = 1'b1;
                if (i_sts.pos_is_one) begin
                    o_cmd.emit_clr = 1'b1;
                    n_state        = S_EMIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rsel  = RSEL_K;
                n_state     = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.emit_inc = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RSS_AST_NEXT(a_accept_starts_div, i_clk, i_rst_n, i_valid && !o_stall, r_state == S_DIV, "accepted request did not start remainder")
    `RSS_AST_NOW(a_load_needs_room, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free, "output register overwritten")
    `RSS_AST_NOW(a_done_only_in_div, i_clk, i_rst_n, i_sts.mod_done, r_state == S_DIV, "remainder done outside divide state")
    `RSS_AST_NEXT(a_last_swap_emits, i_clk, i_rst_n, r_state == S_WR_J && i_sts.pos_is_one, r_state == S_EMIT_RD, "final swap did not start emit")

endmodule

@@ rtl/rejection_sampled_shuffle.sv @@
// The 32-bit remainder unit retires 4 bits a cycle. Each request is finished or
// dropped before the next one is accepted; after the final swap the permutation
// drains through the single memory read port, held off while the output stalls.
// Reset (synchronous, active low): size 15, identity permutation, position 14.
// Depends on rss_pkg, rss_ctrl, rss_datapath, rss_mod.
module rejection_sampled_shuffle
    import rss_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [WORD_W-1:0]     i_random_word,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ITEM_NUM_W-1:0] o_item_number,
    output logic                  o_is_last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    // reset size clipped to what the store can hold
    localparam int SIZE_INIT = (SIZE_RST > MAX_ITEMS) ? MAX_ITEMS : SIZE_RST;

    t_cmd              w_cmd;
    t_sts              w_sts;

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_wr_size;
    logic [SIZE_W-1:0] w_size_eff;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_PERM_SIZE);

    // written size is saturated into [2, MAX_ITEMS]
    always_comb begin
        w_wr_size = pwdata[SIZE_W-1:0];
        if (w_wr_size < SIZE_W'(2)) begin
            w_wr_size = SIZE_W'(2);
        end else if (32'(w_wr_size) > 32'(MAX_ITEMS)) begin
            w_wr_size = SIZE_W'(MAX_ITEMS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(SIZE_INIT);
        end else if (w_cfg_wr) begin
            r_size <= w_wr_size;
        end
    end

    // a size write restarts from the new size in the same edge
    assign w_size_eff = w_cfg_wr ? w_wr_size : r_size;

    assign prdata = (paddr == ADDR_PERM_SIZE) ? PDATA_W'(r_size) : '0;

    rss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    rss_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_restart     (w_cmd.restart || w_cfg_wr),
        .i_size        (w_size_eff),
        .i_random_word (i_random_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item_number (o_item_number),
        .o_is_last     (o_is_last)
    );

endmodule

@@ tb/tb_rejection_sampled_shuffle.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rejection_sampled_shuffle: directed table, then random phases.
// Depends on rss_pkg and the rejection_sampled_shuffle RTL.
module tb_rejection_sampled_shuffle;
    import rss_pkg::*;

    localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT = 400000;  // worst legal run is well under half of this
    localparam int IDLE_WAIT   = 40;      // covers one in-flight word that gives no result
    localparam int END_WAIT    = 20000;
    localparam int TAIL_WAIT   = 60;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef enum {ROW_WORD, ROW_CFG} t_row_kind;

    // one directed row; n_typed < 0 means the predictor supplies the results
    typedef struct {
        t_row_kind          kind;
        logic [PADDR_W-1:0] addr;
        logic [31:0]        value;
        int                 n_typed;
        logic [3:0]         item0;
        logic [3:0]         item1;
    } t_stim_row;

    typedef struct {
        logic [3:0] item;
        logic       last;
    } t_item_res;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [WORD_W-1:0]     i_random_word = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ITEM_NUM_W-1:0] o_item_number;
    logic                  o_is_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // shuffle predictor state
    logic [3:0]  perm_store [0:MAX_ITEMS-1];
    logic [3:0]  emit_item  [0:MAX_ITEMS-1];
    int unsigned cur_pos;
    int unsigned cur_size;
    bit          word_dropped;

    t_item_res   due_items [$];
    t_stim_row   stim_rows [$];

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int words_sent   = 0;
    int words_drop   = 0;
    int results_seen = 0;
    int size_writes  = 0;
    int burst_left   = 1;

    rejection_sampled_shuffle #(
        .MAX_ITEMS(MAX_ITEMS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_random_word (i_random_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item_number (o_item_number),
        .o_is_last     (o_is_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // watchdog: hang or lost handshake
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due", cycle_cnt, due_items.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void perm_restart();
        for (int k = 0; k < MAX_ITEMS; k++) begin
            perm_store[k] = 4'(k);
        end
        cur_pos = cur_size - 1;
    endfunction

    // largest multiple of bound that fits in 2^32; words at or above it are dropped
    function automatic longint unsigned accept_limit(longint unsigned bound);
        return ((64'd1 << 32) / bound) * bound;
    endfunction

    // one swap step; returns how many items it emits (0 or cur_size)
    function automatic int shuffle_step(logic [31:0] w);
        longint unsigned bound;
        int unsigned     j;
        logic [3:0]      tmp;
        int              n_out;
        word_dropped = 1'b0;
        if (cur_pos == 0 || cur_pos >= MAX_ITEMS) begin
            perm_restart();
        end
        bound = cur_pos + 1;
        if (64'(w) >= accept_limit(bound)) begin
            word_dropped = 1'b1;
            return 0;
        end
        j = int'(64'(w) % bound);
        tmp = perm_store[cur_pos];
        perm_store[cur_pos] = perm_store[j];
        perm_store[j] = tmp;
        cur_pos--;
        if (cur_pos != 0) begin
            return 0;
        end
        n_out = cur_size;
        for (int k = 0; k < n_out; k++) begin
            emit_item[k] = perm_store[k];
        end
        perm_restart();
        return n_out;
    endfunction

    // size register write: low 5 bits, saturated to 2..MAX_ITEMS, restarts
    function automatic void size_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
        int unsigned v;
        if (addr != ADDR_PERM_SIZE) begin
            return;
        end
        v = value & 32'h1F;
        if (v < 2) begin
            v = 2;
        end
        if (v > MAX_ITEMS) begin
            v = MAX_ITEMS;
        end
        cur_size = v;
        perm_restart();
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic flag_error(input string msg);
        if (err_cnt < 10) begin
            $display("[%0d] %s", cycle_cnt, msg);
        end
        err_cnt++;
    endtask

    task automatic push_due(input logic [3:0] item, input logic last);
        t_item_res r;
        r.item = item;
        r.last = last;
        due_items.insert(due_items.size(), r);
    endtask

    // bursts of random length, with a random gap after each burst
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // present one request and hold it until accepted
    task automatic send_word(input logic [31:0] w, input bit predicted);
        int n_out;
        i_valid       <= 1'b1;
        i_random_word <= w;
        do @(posedge i_clk); while (o_stall);
        n_out = shuffle_step(w);
        words_sent++;
        if (word_dropped) begin
            words_drop++;
        end
        if (predicted) begin
            for (int k = 0; k < n_out; k++) begin
                push_due(emit_item[k], k == n_out - 1);
            end
        end
        pace_sender();
    endtask

    // hold off requests until every due result is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_items.size() != 0);
    endtask

    // idle point: drained, plus time for a word that produces nothing
    task automatic settle();
        drain();
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // APB write: setup, access, wait for pready, then back to idle
    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_write(addr, value);
        size_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(input t_row_kind kind, input logic [PADDR_W-1:0] addr,
                           input logic [31:0] value, input int n_typed,
                           input logic [3:0] item0, input logic [3:0] item1);
        t_stim_row r;
        r.kind    = kind;
        r.addr    = addr;
        r.value   = value;
        r.n_typed = n_typed;
        r.item0   = item0;
        r.item1   = item1;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // random word: mostly uniform, some near the top, near zero, or at the rejection edge
    function automatic logic [31:0] pick_word();
        longint unsigned lim;
        longint unsigned v;
        int              sel;
        lim = accept_limit(cur_pos + 1);
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return $urandom;
        end else if (sel < 75) begin
            return 32'hFFFF_FFFF - $urandom_range(0, 15);
        end else if (sel < 85) begin
            return $urandom_range(0, 31);
        end
        v = lim - 1 + $urandom_range(0, 2);
        if (v > 64'hFFFF_FFFF) begin
            v = 64'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // stall pattern: free-running, coin flips, short solid stalls, alternating
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 2) ? $urandom_range(1, 20) : $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= $urandom_range(0, 1);
                2: i_stall <= 1'b1;
                default: i_stall <= cycle_cnt[0];
            endcase
        end
    end

    // compare every accepted result with the oldest due one
    always @(posedge i_clk) begin
        t_item_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (due_items.size() == 0) begin
                flag_error($sformatf("unexpected result item=%0d last=%0b",
                                     o_item_number, o_is_last));
            end else begin
                want = due_items.pop_front();
                if (o_item_number !== want.item || o_is_last !== want.last) begin
                    flag_error($sformatf("mismatch: want item=%0d last=%0b, got item=%0d last=%0b",
                                         want.item, want.last, o_item_number, o_is_last));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int          sizes [12] = '{16, 2, 9, 0, 13, 31, 3, 7, 1, 12, 5, 17};
        int          n_items;
        logic [31:0] wr_val;
        t_stim_row   row;

        // directed table
        // reset size 15: top word is dropped at bound 15
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, 0, 4'd0, 4'd0);
        // size 2: one word finishes a permutation
        add_row(ROW_CFG,  ADDR_PERM_SIZE, 32'd2,         -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0000, 2, 4'd1, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0001, 2, 4'd0, 4'd1);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, 2, 4'd0, 4'd1);
        // sizes 0 and 1 saturate up to 2
        add_row(ROW_CFG,  ADDR_PERM_SIZE, 32'd0,         -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFE, 2, 4'd1, 4'd0);
        add_row(ROW_CFG,  ADDR_PERM_SIZE, 32'd1,         -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h8000_0000, 2, 4'd1, 4'd0);
        // size 3: only the all-ones word is dropped at bound 3
        add_row(ROW_CFG,  ADDR_PERM_SIZE, 32'd3,         -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, 0, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFE, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0005, -1, 4'd0, 4'd0);
        // upper data bits ignored: 0x...F0 gives 16
        add_row(ROW_CFG,  ADDR_PERM_SIZE, 32'hFFFF_FFF0, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, -1, 4'd0, 4'd0);  // bound 16, kept
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, 0, 4'd0, 4'd0);   // bound 15, dropped
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0000, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h1234_5678, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFF7, 0, 4'd0, 4'd0);   // bound 13, at limit
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFF6, -1, 4'd0, 4'd0);  // just below limit
        // write outside the register map: no restart
        add_row(ROW_CFG,  ADDR_UNUSED,    32'd2,         -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hAAAA_AAAA, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h5555_5555, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h7FFF_FFFF, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h8000_0000, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hDEAD_BEEF, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0F0F_0F0F, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hF0F0_F0F0, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0001, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'hFFFF_FFFF, -1, 4'd0, 4'd0);  // bound 4
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0003, -1, 4'd0, 4'd0);
        add_row(ROW_WORD, ADDR_PERM_SIZE, 32'h0000_0002, -1, 4'd0, 4'd0);  // completes 16

        // reset, predictor to its reset state
        cur_size = SIZE_RST;
        perm_restart();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.addr, row.value);
            end else begin
                send_word(row.value, row.n_typed < 0);
                if (row.n_typed == 2) begin
                    push_due(row.item0, 1'b0);
                    push_due(row.item1, 1'b1);
                end
            end
        end

        // random phases, one size setting each
        foreach (sizes[p]) begin
            settle();
            wr_val = sizes[p];
            if ($urandom_range(0, 1)) begin
                wr_val = ($urandom & ~32'h1F) | wr_val;
            end
            cfg_write(ADDR_PERM_SIZE, wr_val);
            if (p == 5) begin
                cfg_write(ADDR_UNUSED, $urandom);
            end
            n_items = $urandom_range(22, 32);
            for (int i = 0; i < n_items; i++) begin
                // mid-phase pause until everything is back
                if (p % 3 == 1 && i == n_items / 2) begin
                    drain();
                end
                send_word(pick_word(), 1'b1);
            end
        end

        // wind down
        i_valid <= 1'b0;
        for (int t = 0; t < END_WAIT && due_items.size() != 0; t++) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (due_items.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", due_items.size()));
        end

        $display("Sent %0d words (%0d dropped by rejection), checked %0d results, %0d config writes",
                 words_sent, words_drop, results_seen, size_writes);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d errors", err_cnt);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
